// ===== sv/tpq_pkg.sv =====
// Package for the two-class priority queue unit.
// Holds widths, opcodes, register indexes, the controller state type and shared structs.
// No dependencies; the interfaces, engine, top level, checker and testbench import it.
package tpq_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int ID_MAX_DEF   = 65535;

    localparam int ID_W       = 16;
    localparam int ENTRY_W    = ID_W + 1;
    localparam int CNT_OUT_W  = 6;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_DEPART = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_LANE_NUMBER = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LANE_KIND   = 8'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_SHIFT_DN,
        ST_SHIFT_UP,
        ST_PLACE,
        ST_RESP
    } tpq_state_t;

    typedef struct packed {
        logic [ID_W-1:0] lane_number;
        logic            lane_kind;
    } tpq_cfg_t;

    typedef struct packed {
        logic                 success;
        logic                 id_was_present;
        logic [CNT_OUT_W-1:0] entry_count;
        logic [CNT_OUT_W-1:0] urgent_count;
    } tpq_result_t;

endpackage

// ===== sv/tpq_req_if.sv =====
// Request channel of the two-class priority queue unit.
// Carries valid, ready and one operation; depends on tpq_pkg.
interface tpq_req_if;
    import tpq_pkg::*;

    logic            valid;
    logic            ready;
    logic [1:0]      opcode;
    logic [ID_W-1:0] entry_id;
    logic            entry_kind;
    logic            urgent;

    modport source (output valid, output opcode, output entry_id, output entry_kind,
                    output urgent, input ready);
    modport sink   (input valid, input opcode, input entry_id, input entry_kind,
                    input urgent, output ready);
endinterface

// ===== sv/tpq_rsp_if.sv =====
// Response channel of the two-class priority queue unit.
// Carries valid, ready and one result; depends on tpq_pkg.
interface tpq_rsp_if;
    import tpq_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 success;
    logic                 id_was_present;
    logic [CNT_OUT_W-1:0] entry_count;
    logic [CNT_OUT_W-1:0] urgent_count;

    modport source (output valid, output success, output id_was_present,
                    output entry_count, output urgent_count, input ready);
    modport sink   (input valid, input success, input id_was_present,
                    input entry_count, input urgent_count, output ready);
endinterface

// ===== sv/tpq_cfg_if.sv =====
// Configuration write channel of the two-class priority queue unit.
// Carries valid, ready, a register index and write data; depends on tpq_pkg.
interface tpq_cfg_if;
    import tpq_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/tpq_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module tpq_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/tpq_engine.sv =====
// Sequencer of the two-class priority queue: scans, shifts and writes the entry RAM.
// Keeps the occupancy counts. Depends on tpq_pkg; drives one tpq_ram instance.
module tpq_engine #(
    parameter int CAPACITY = tpq_pkg::CAPACITY_DEF,
    parameter int ID_MAX   = tpq_pkg::ID_MAX_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [1:0]                        op,
    input  logic [tpq_pkg::ID_W-1:0]          id,
    input  logic                              kind,
    input  logic                              urg,
    input  tpq_pkg::tpq_cfg_t                 cfg,
    output logic                              idle,
    output logic                              res_valid,
    input  logic                              res_take,
    output tpq_pkg::tpq_result_t              res,
    output logic                              ram_we,
    output logic [$clog2(CAPACITY)-1:0]       ram_waddr,
    output logic [tpq_pkg::ENTRY_W-1:0]       ram_wdata,
    output logic                              ram_re,
    output logic [$clog2(CAPACITY)-1:0]       ram_raddr,
    input  logic [tpq_pkg::ENTRY_W-1:0]       ram_rdata
);
    import tpq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    tpq_state_t      state_reg, state_next;
    logic [1:0]      op_reg, op_next;
    logic [ID_W-1:0] id_reg, id_next;
    logic            kind_reg, kind_next;
    logic            urg_reg, urg_next;
    logic            id_valid_reg, id_valid_next;
    logic [CW-1:0]   idx_reg, idx_next;
    logic [CW-1:0]   dst_reg, dst_next;
    logic            rvalid_reg, rvalid_next;
    logic            found_reg, found_next;
    logic [CW-1:0]   pos_reg, pos_next;
    logic            pos_urg_reg, pos_urg_next;
    logic            head_urg_reg, head_urg_next;
    logic            success_reg, success_next;
    logic            present_reg, present_next;
    logic [CW-1:0]   occ_reg, occ_next;
    logic [CW-1:0]   uocc_reg, uocc_next;

    logic            scan_issue, scan_done;
    logic            dn_issue, dn_done;
    logic            up_issue, up_done;
    logic            lane_ok, add_ok, drop_ok;
    logic [CW-1:0]   ins_pos;
    logic [CW-1:0]   idx_dec, idx_inc;
    logic            rd_match;

    assign idx_dec = idx_reg - CW'(1);
    assign idx_inc = idx_reg + CW'(1);

    assign scan_issue = (state_reg == ST_SCAN) && (idx_reg < occ_reg);
    assign scan_done  = (state_reg == ST_SCAN) && !scan_issue && !rvalid_reg;
    assign dn_issue   = (state_reg == ST_SHIFT_DN) && (idx_reg > pos_reg);
    assign dn_done    = (state_reg == ST_SHIFT_DN) && !dn_issue && !rvalid_reg;
    assign up_issue   = (state_reg == ST_SHIFT_UP)
                        && ({1'b0, idx_reg} + (CW + 1)'(1) < {1'b0, occ_reg});
    assign up_done    = (state_reg == ST_SHIFT_UP) && !up_issue && !rvalid_reg;

    assign lane_ok = (cfg.lane_number >= ID_W'(1)) && (cfg.lane_number <= ID_W'(ID_MAX));
    assign add_ok  = (op_reg == OP_ADD) && id_valid_reg && lane_ok
                     && (kind_reg == cfg.lane_kind) && !found_reg
                     && (occ_reg < CW'(CAPACITY));
    assign drop_ok = ((op_reg == OP_REMOVE) && found_reg)
                     || ((op_reg == OP_DEPART) && (occ_reg != '0));
    // Urgent adds go right behind the last urgent entry, normal adds at the tail.
    assign ins_pos = (urg_reg && (uocc_reg < occ_reg)) ? uocc_reg : occ_reg;
    assign rd_match = (ram_rdata[ENTRY_W-1:1] == id_reg) && id_valid_reg && !found_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                priority if (add_ok)
                begin
                    state_next = ST_SHIFT_DN;
                end
                else if (drop_ok)
                begin
                    state_next = ST_SHIFT_UP;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end
            ST_SHIFT_DN:
            begin
                if (dn_done)
                begin
                    state_next = ST_PLACE;
                end
            end
            ST_SHIFT_UP:
            begin
                if (up_done)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_PLACE:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and RAM controls.
    always_comb
    begin
        op_next       = op_reg;
        id_next       = id_reg;
        kind_next     = kind_reg;
        urg_next      = urg_reg;
        id_valid_next = id_valid_reg;
        idx_next      = idx_reg;
        dst_next      = dst_reg;
        rvalid_next   = 1'b0;
        found_next    = found_reg;
        pos_next      = pos_reg;
        pos_urg_next  = pos_urg_reg;
        head_urg_next = head_urg_reg;
        success_next  = success_reg;
        present_next  = present_reg;
        occ_next      = occ_reg;
        uocc_next     = uocc_reg;
        ram_we        = 1'b0;
        ram_waddr     = dst_reg[AW-1:0];
        ram_wdata     = ram_rdata;
        ram_re        = 1'b0;
        ram_raddr     = idx_reg[AW-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next       = op;
                    id_next       = id;
                    kind_next     = kind;
                    urg_next      = urg;
                    id_valid_next = (id >= ID_W'(1)) && (id <= ID_W'(ID_MAX));
                    idx_next      = '0;
                    found_next    = 1'b0;
                    head_urg_next = 1'b0;
                end
            end
            ST_SCAN:
            begin
                if (scan_issue)
                begin
                    ram_re      = 1'b1;
                    ram_raddr   = idx_reg[AW-1:0];
                    dst_next    = idx_reg;
                    rvalid_next = 1'b1;
                    idx_next    = idx_inc;
                end
                if (rvalid_reg)
                begin
                    if (rd_match)
                    begin
                        found_next   = 1'b1;
                        pos_next     = dst_reg;
                        pos_urg_next = ram_rdata[0];
                    end
                    if (dst_reg == '0)
                    begin
                        head_urg_next = ram_rdata[0];
                    end
                end
            end
            ST_DECIDE:
            begin
                success_next = add_ok || drop_ok;
                present_next = found_reg;
                if (op_reg == OP_ADD)
                begin
                    pos_next = ins_pos;
                    idx_next = occ_reg;
                end
                else if (op_reg == OP_DEPART)
                begin
                    pos_next     = '0;
                    idx_next     = '0;
                    pos_urg_next = head_urg_reg;
                end
                else
                begin
                    idx_next = pos_reg;
                end
            end
            ST_SHIFT_DN:
            begin
                // Reads run one slot ahead of the writes, so no slot is overwritten unread.
                if (dn_issue)
                begin
                    ram_re      = 1'b1;
                    ram_raddr   = idx_dec[AW-1:0];
                    dst_next    = idx_reg;
                    rvalid_next = 1'b1;
                    idx_next    = idx_dec;
                end
                if (rvalid_reg)
                begin
                    ram_we = 1'b1;
                end
            end
            ST_SHIFT_UP:
            begin
                if (up_issue)
                begin
                    ram_re      = 1'b1;
                    ram_raddr   = idx_inc[AW-1:0];
                    dst_next    = idx_reg;
                    rvalid_next = 1'b1;
                    idx_next    = idx_inc;
                end
                if (rvalid_reg)
                begin
                    ram_we = 1'b1;
                end
                if (up_done)
                begin
                    occ_next = occ_reg - CW'(1);
                    if (pos_urg_reg && (uocc_reg != '0))
                    begin
                        uocc_next = uocc_reg - CW'(1);
                    end
                end
            end
            ST_PLACE:
            begin
                ram_we    = 1'b1;
                ram_waddr = pos_reg[AW-1:0];
                ram_wdata = {id_reg, urg_reg};
                occ_next  = occ_reg + CW'(1);
                uocc_next = uocc_reg + CW'(urg_reg);
            end
            ST_RESP:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            rvalid_reg <= 1'b0;
            occ_reg    <= '0;
            uocc_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            rvalid_reg <= rvalid_next;
            occ_reg    <= occ_next;
            uocc_reg   <= uocc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        id_reg       <= id_next;
        kind_reg     <= kind_next;
        urg_reg      <= urg_next;
        id_valid_reg <= id_valid_next;
        idx_reg      <= idx_next;
        dst_reg      <= dst_next;
        found_reg    <= found_next;
        pos_reg      <= pos_next;
        pos_urg_reg  <= pos_urg_next;
        head_urg_reg <= head_urg_next;
        success_reg  <= success_next;
        present_reg  <= present_next;
    end

    assign idle                 = (state_reg == ST_IDLE);
    assign res_valid            = (state_reg == ST_RESP);
    assign res.success          = success_reg;
    assign res.id_was_present   = present_reg;
    assign res.entry_count      = CNT_OUT_W'(occ_reg);
    assign res.urgent_count     = CNT_OUT_W'(uocc_reg);

endmodule

// ===== sv/two_class_priority_queue_unit.sv =====
// Two-class priority queue unit: holds up to CAPACITY unique identifiers in one ordered
// list in RAM, urgent entries ahead of normal ones, each class in arrival order.
// Channels: req takes one operation per transaction (add, remove by id, depart head),
// rsp returns one result per operation (success, prior presence, both counts), and
// cfg writes lane_number (index 0) and lane_kind (index 1); cfg is always ready.
// The unit works on one operation at a time. Its work depends on N, the occupancy (the
// duplicate and position scan reads one RAM entry per cycle), and on M, the number of
// entries that must move for an insertion or removal (one entry per cycle through the
// RAM's single read and write port); a refused operation only scans. A new request is
// accepted from the cycle in which the previous result appears.
// The result is held in an output register; the next operation is accepted while it
// waits, and that operation only stalls at its own result if rsp is still blocked.
// Reset empties the queue at once through the counts (no clearing pass) and sets
// lane_number to 1 and lane_kind to 0. Depends on tpq_pkg, the channel interfaces,
// tpq_engine and tpq_ram.
module two_class_priority_queue_unit #(
    parameter int CAPACITY = tpq_pkg::CAPACITY_DEF,
    parameter int ID_MAX   = tpq_pkg::ID_MAX_DEF
) (
    input logic       clk,
    input logic       rst_n,
    tpq_req_if.sink   req,
    tpq_rsp_if.source rsp,
    tpq_cfg_if.sink   cfg
);
    import tpq_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    tpq_cfg_t    cfg_reg, cfg_next;
    logic        out_valid_reg, out_valid_next;
    tpq_result_t out_reg, out_next;

    logic               eng_idle;
    logic               res_valid;
    logic               res_take;
    tpq_result_t        res;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    assign req.ready = eng_idle;
    assign cfg.ready = 1'b1;
    assign res_take  = res_valid && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            if (cfg.index == REG_LANE_NUMBER)
            begin
                cfg_next.lane_number = cfg.data[ID_W-1:0];
            end
            else if (cfg.index == REG_LANE_KIND)
            begin
                cfg_next.lane_kind = cfg.data[0];
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lane_number <= ID_W'(1);
            cfg_reg.lane_kind   <= 1'b0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.success        = out_reg.success;
    assign rsp.id_was_present = out_reg.id_was_present;
    assign rsp.entry_count    = out_reg.entry_count;
    assign rsp.urgent_count   = out_reg.urgent_count;

    tpq_engine #(
        .CAPACITY (CAPACITY),
        .ID_MAX   (ID_MAX)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (req.valid && eng_idle),
        .op        (req.opcode),
        .id        (req.entry_id),
        .kind      (req.entry_kind),
        .urg       (req.urgent),
        .cfg       (cfg_reg),
        .idle      (eng_idle),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    tpq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

// ===== sv/tpq_checker.sv =====
// Port-level checks for the two-class priority queue unit, attached by bind.
// Depends on tpq_pkg and the top level two_class_priority_queue_unit.
module tpq_checker #(
    parameter int CAPACITY = tpq_pkg::CAPACITY_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic                          rsp_success,
    input logic                          rsp_id_was_present,
    input logic [tpq_pkg::CNT_OUT_W-1:0] rsp_entry_count,
    input logic [tpq_pkg::CNT_OUT_W-1:0] rsp_urgent_count
);
    import tpq_pkg::*;

    // A stalled result keeps its value until the transaction completes.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid
            && $stable({rsp_success, rsp_id_was_present, rsp_entry_count, rsp_urgent_count}))
        else $error("response changed while stalled");

    // One operation at a time: a request transaction is followed by a busy cycle.
    a_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while an operation was in progress");

    // A fresh result is presented only once the sequencer has finished its operation.
    a_rsp_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> req_ready)
        else $error("result presented while the sequencer was busy");

    // Urgent entries are a subset of all entries; checked only while CAPACITY fits the count width.
    a_counts: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (CAPACITY > 63) || (rsp_urgent_count <= rsp_entry_count))
        else $error("urgent count exceeds entry count");

endmodule

bind two_class_priority_queue_unit tpq_checker #(
    .CAPACITY (CAPACITY)
) u_tpq_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .req_valid          (req.valid),
    .req_ready          (req.ready),
    .rsp_valid          (rsp.valid),
    .rsp_ready          (rsp.ready),
    .rsp_success        (rsp.success),
    .rsp_id_was_present (rsp.id_was_present),
    .rsp_entry_count    (rsp.entry_count),
    .rsp_urgent_count   (rsp.urgent_count)
);

// ===== sim/testbench.sv =====
// Self-checking testbench for two_class_priority_queue_unit.
// Drives directed and random queue operations with random idling and back-pressure and compares
// every result with a behavioural queue model. Depends on tpq_pkg and the three channel interfaces.
module testbench;
    import tpq_pkg::*;

    localparam logic [1:0]  OP_UNUSED   = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int          DRAIN_TAIL  = 80;

    typedef struct packed {
        logic [1:0]      opcode;
        logic [ID_W-1:0] entry_id;
        logic            entry_kind;
        logic            urgent;
    } tpq_op_t;

    logic clk = 1'b0;
    logic rst_n;

    tpq_req_if req_bus ();
    tpq_rsp_if rsp_bus ();
    tpq_cfg_if cfg_bus ();

    two_class_priority_queue_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus),
        .cfg   (cfg_bus)
    );

    always #5 clk = ~clk;

    // Shadow of the configuration registers and of the ordered list, head first.
    logic [ID_W-1:0] lane_number = 16'd1;
    logic            lane_kind   = 1'b0;
    logic [ID_W-1:0] lane_ids[$];
    bit              lane_urgent[$];
    int              urgent_held = 0;

    tpq_result_t pending_results[$];
    int          error_count     = 0;
    bit          req_idle_on     = 1'b0;
    bit          rsp_idle_on     = 1'b0;
    int          rsp_hold_cycles = 0;
    int unsigned cycle_count     = 0;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Applies one operation to the shadow list and returns the result it must produce.
    function automatic tpq_result_t apply_queue_op(input tpq_op_t op);
        tpq_result_t res;
        int          pos;
        bit          id_valid;
        bit          found;
        id_valid = (op.entry_id != 0) && (op.entry_id <= ID_MAX_DEF);
        pos = -1;
        if (id_valid)
        begin
            for (int i = 0; i < lane_ids.size() && pos < 0; i++)
            begin
                if (lane_ids[i] == op.entry_id)
                    pos = i;
            end
        end
        found = (pos >= 0);
        res.success = 1'b0;
        case (op.opcode)
            OP_ADD:
            begin
                if (id_valid && lane_number != 0 && lane_number <= ID_MAX_DEF &&
                    op.entry_kind == lane_kind && !found && lane_ids.size() < CAPACITY_DEF)
                begin
                    if (op.urgent)
                    begin
                        lane_ids.insert(urgent_held, op.entry_id);
                        lane_urgent.insert(urgent_held, 1'b1);
                        urgent_held++;
                    end
                    else
                    begin
                        lane_ids.push_back(op.entry_id);
                        lane_urgent.push_back(1'b0);
                    end
                    res.success = 1'b1;
                end
            end
            OP_REMOVE:
            begin
                if (found)
                begin
                    if (lane_urgent[pos])
                        urgent_held--;
                    lane_ids.delete(pos);
                    lane_urgent.delete(pos);
                    res.success = 1'b1;
                end
            end
            OP_DEPART:
            begin
                if (lane_ids.size() > 0)
                begin
                    if (lane_urgent[0])
                        urgent_held--;
                    void'(lane_ids.pop_front());
                    void'(lane_urgent.pop_front());
                    res.success = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        res.id_was_present = found;
        res.entry_count    = CNT_OUT_W'(lane_ids.size());
        res.urgent_count   = CNT_OUT_W'(urgent_held);
        return res;
    endfunction

    // Offers one operation and records its expected result once the transaction is accepted.
    task automatic send_op(input logic [1:0] opcode, input logic [ID_W-1:0] id,
                           input logic kind, input logic urg);
        tpq_op_t op;
        int      gap;
        op.opcode     = opcode;
        op.entry_id   = id;
        op.entry_kind = kind;
        op.urgent     = urg;
        gap = req_idle_on ? $urandom_range(0, 13) : 0;
        if (gap != 0)
        begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_bus.valid      <= 1'b1;
        req_bus.opcode     <= op.opcode;
        req_bus.entry_id   <= op.entry_id;
        req_bus.entry_kind <= op.entry_kind;
        req_bus.urgent     <= op.urgent;
        do @(posedge clk); while (!req_bus.ready);
        pending_results.push_back(apply_queue_op(op));
    endtask

    // Always waits for a clock edge, so valid is never lowered and raised in one step.
    task automatic wait_drained();
        req_bus.valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
    endtask

    task automatic set_lane(input logic [ID_W-1:0] number, input logic kind);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= REG_LANE_NUMBER;
        cfg_bus.data  <= number;
        do @(posedge clk); while (!cfg_bus.ready);
        lane_number = number;
        cfg_bus.index <= REG_LANE_KIND;
        cfg_bus.data  <= {{(CFG_DATA_W-1){1'b0}}, kind};
        do @(posedge clk); while (!cfg_bus.ready);
        lane_kind = kind;
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic check_result(input tpq_result_t got);
        tpq_result_t want;
        if (pending_results.size() == 0)
        begin
            $error("result transaction with no operation outstanding");
            error_count++;
            return;
        end
        want = pending_results.pop_front();
        if (got.success !== want.success)
        begin
            $error("success: expected %0d, got %0d", want.success, got.success);
            error_count++;
        end
        if (got.id_was_present !== want.id_was_present)
        begin
            $error("id_was_present: expected %0d, got %0d", want.id_was_present,
                   got.id_was_present);
            error_count++;
        end
        if (got.entry_count !== want.entry_count)
        begin
            $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
            error_count++;
        end
        if (got.urgent_count !== want.urgent_count)
        begin
            $error("urgent_count: expected %0d, got %0d", want.urgent_count, got.urgent_count);
            error_count++;
        end
    endtask

    initial
    begin : result_sink
        int          stall;
        tpq_result_t got;
        rsp_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            // A requested hold-off is taken before the next transaction is allowed.
            if (rsp_hold_cycles != 0)
            begin
                rsp_bus.ready <= 1'b0;
                repeat (rsp_hold_cycles) @(posedge clk);
                rsp_hold_cycles = 0;
            end
            stall = rsp_idle_on ? $urandom_range(0, 13) : 0;
            if (stall != 0)
            begin
                rsp_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_bus.ready <= 1'b1;
            do @(posedge clk); while (!rsp_bus.valid);
            got.success        = rsp_bus.success;
            got.id_was_present = rsp_bus.id_was_present;
            got.entry_count    = rsp_bus.entry_count;
            got.urgent_count   = rsp_bus.urgent_count;
            check_result(got);
        end
    end

    task automatic test_directed_ops();
        req_idle_on = 1'b1;
        rsp_idle_on = 1'b1;
        send_op(OP_DEPART, 16'd0, 1'b0, 1'b0);
        send_op(OP_REMOVE, 16'd5, 1'b0, 1'b0);
        send_op(OP_ADD, 16'd0, 1'b0, 1'b0);
        send_op(OP_ADD, 16'hFFFF, 1'b0, 1'b0);
        send_op(OP_ADD, 16'd1, 1'b0, 1'b1);
        send_op(OP_ADD, 16'hFFFF, 1'b0, 1'b1);
        send_op(OP_ADD, 16'd7, 1'b1, 1'b0);
        send_op(OP_UNUSED, 16'd1, 1'b1, 1'b1);
        send_op(OP_REMOVE, 16'd0, 1'b0, 1'b0);
        send_op(OP_ADD, 16'd2, 1'b0, 1'b1);
        send_op(OP_ADD, 16'd3, 1'b0, 1'b0);
        send_op(OP_REMOVE, 16'hFFFF, 1'b1, 1'b1);
        send_op(OP_REMOVE, 16'd1, 1'b0, 1'b0);
        send_op(OP_DEPART, 16'd3, 1'b1, 1'b1);
        send_op(OP_DEPART, 16'hFFFF, 1'b0, 1'b0);
        send_op(OP_DEPART, 16'd2, 1'b0, 1'b0);
        wait_drained();
    endtask

    task automatic test_lane_settings();
        // A lane number of zero refuses every add, whatever the kind.
        set_lane(16'd0, 1'b1);
        send_op(OP_ADD, 16'd9, 1'b1, 1'b0);
        send_op(OP_ADD, 16'd9, 1'b0, 1'b1);
        wait_drained();
        set_lane(16'hFFFF, 1'b1);
        send_op(OP_ADD, 16'd9, 1'b1, 1'b1);
        send_op(OP_ADD, 16'd10, 1'b0, 1'b0);
        send_op(OP_ADD, 16'd11, 1'b1, 1'b0);
        send_op(OP_DEPART, 16'd11, 1'b0, 1'b0);
        send_op(OP_REMOVE, 16'd11, 1'b0, 1'b0);
        wait_drained();
    endtask

    task automatic test_full_queue_backpressure();
        // The result side stalls for a long stretch while adds keep coming, so the
        // unit fills its output register and stops accepting requests.
        req_idle_on = 1'b0;
        rsp_idle_on = 1'b0;
        rsp_hold_cycles = 400;
        for (int k = 0; k <= CAPACITY_DEF; k++)
            send_op(OP_ADD, ID_W'(100 + k), lane_kind, 1'($urandom_range(0, 1)));
        wait_drained();
        rsp_idle_on = 1'b1;
        send_op(OP_REMOVE, 16'd115, lane_kind, 1'b0);
        while (lane_ids.size() != 0)
            send_op(OP_DEPART, ID_W'($urandom()), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
        send_op(OP_DEPART, 16'd100, 1'b0, 1'b0);
        wait_drained();
    endtask

    function automatic logic [ID_W-1:0] pick_entry_id();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 80)
            return ID_W'($urandom_range(1, 48));
        else if (roll < 85)
            return 16'd0;
        else if (roll < 90)
            return 16'hFFFF;
        return ID_W'($urandom());
    endfunction

    task automatic send_random_op(input int add_pct);
        int              roll;
        logic [1:0]      opcode;
        logic [ID_W-1:0] id;
        logic            kind;
        logic            urg;
        roll = $urandom_range(0, 99);
        if (roll < add_pct)
            opcode = OP_ADD;
        else if (roll < add_pct + (95 - add_pct) / 2)
            opcode = OP_REMOVE;
        else if (roll < 95)
            opcode = OP_DEPART;
        else
            opcode = OP_UNUSED;
        id = pick_entry_id();
        if (opcode != OP_ADD && lane_ids.size() != 0 && $urandom_range(0, 99) < 65)
            id = lane_ids[$urandom_range(0, lane_ids.size() - 1)];
        kind = ($urandom_range(0, 99) < 88) ? lane_kind : ~lane_kind;
        urg  = ($urandom_range(0, 2) == 0);
        send_op(opcode, id, kind, urg);
    endtask

    task automatic run_random_phase(input int n_items);
        int add_pct;
        add_pct = 55;
        for (int k = 0; k < n_items; k++)
        begin
            // Bursts that mostly add fill the queue; the others drain it again.
            if (k % 40 == 0)
            begin
                case ($urandom_range(0, 2))
                    0: add_pct = 25;
                    1: add_pct = 55;
                    default: add_pct = 85;
                endcase
            end
            send_random_op(add_pct);
        end
        wait_drained();
    endtask

    task automatic test_random_phases();
        set_lane(16'd1, 1'b0);
        req_idle_on = 1'b1;
        rsp_idle_on = 1'b1;
        run_random_phase(220);
        set_lane(16'hFFFF, 1'b1);
        req_idle_on = 1'b0;
        rsp_idle_on = 1'b0;
        run_random_phase(220);
        set_lane(16'd0, 1'b0);
        req_idle_on = 1'b1;
        rsp_idle_on = 1'b1;
        run_random_phase(60);
        set_lane(16'h8000, 1'b0);
        req_idle_on = 1'b1;
        rsp_idle_on = 1'b0;
        run_random_phase(220);
        set_lane(16'h1234, 1'b1);
        req_idle_on = 1'b0;
        rsp_idle_on = 1'b1;
        run_random_phase(220);
        set_lane(16'd1, 1'b1);
        req_idle_on = 1'b1;
        rsp_idle_on = 1'b1;
        run_random_phase(220);
        set_lane(16'h7FFF, 1'b0);
        req_idle_on = 1'b0;
        rsp_idle_on = 1'b0;
        run_random_phase(220);
    endtask

    initial
    begin
        rst_n              <= 1'b0;
        req_bus.valid      <= 1'b0;
        req_bus.opcode     <= OP_ADD;
        req_bus.entry_id   <= '0;
        req_bus.entry_kind <= 1'b0;
        req_bus.urgent     <= 1'b0;
        cfg_bus.valid      <= 1'b0;
        cfg_bus.index      <= REG_LANE_NUMBER;
        cfg_bus.data       <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_ops();
        test_lane_settings();
        test_full_queue_backpressure();
        test_random_phases();
        wait_drained();
        repeat (DRAIN_TAIL) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== two_class_priority_queue_unit.f =====
sv/tpq_pkg.sv
sv/tpq_req_if.sv
sv/tpq_rsp_if.sv
sv/tpq_cfg_if.sv
sv/tpq_ram.sv
sv/tpq_engine.sv
sv/two_class_priority_queue_unit.sv
sv/tpq_checker.sv
sim/testbench.sv
